[hw/rtl/bnms_pkg.sv]
package bnms_pkg;

   localparam int MaxBoxes = 64;
   localparam int IdxW     = $clog2(MaxBoxes);
   localparam int CntW     = $clog2(MaxBoxes + 1);
   localparam logic [15:0] ThrReset = 16'd16384;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic [15:0] score;
      logic        pre_rejected;
      logic        last_box;
   } req_type;

   typedef struct packed {
      logic [15:0] kept_x;
      logic [15:0] kept_y;
      logic [15:0] kept_width;
      logic [15:0] kept_height;
      logic [15:0] kept_score;
      logic        end_of_set;
      logic        overflowed;
   } rsp_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [15:0] score;
      logic        supp;
      logic        valid;
   } box_type;

   // control from sequencer to every cell
   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
      logic test;
   } ctl_type;

endpackage

[hw/rtl/bnms_iou.sv]
// Overlap test of a probe box against one held box; two register stages.
module bnms_iou (
   input  logic                 clock,
   input  bnms_pkg::box_type    probe,
   input  bnms_pkg::box_type    held,
   input  logic [15:0]          thr,
   output logic                 hit
);
   logic signed [18:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
   logic signed [18:0] ix1, ix2, iy1, iy2;
   logic [18:0] dx_in, dy_in;
   logic        ok_in;
   logic [18:0] dx_ff, dy_ff;
   logic        ok_ff;
   logic [15:0] aw_ff, ah_ff, bw_ff, bh_ff, thr_ff;
   logic [37:0] inter_in, inter_ff;
   logic [33:0] aa_in, ab_in, aa_ff, ab_ff;
   logic        ok2_ff;
   logic [15:0] thr2_ff;
   logic [35:0] uni;
   logic [52:0] lhs, rhs;

   always_comb begin
      ax1 = $signed({2'b0, probe.x, 1'b0}) - $signed({3'b0, probe.w});
      ax2 = $signed({2'b0, probe.x, 1'b0}) + $signed({3'b0, probe.w});
      ay1 = $signed({2'b0, probe.y, 1'b0}) - $signed({3'b0, probe.h});
      ay2 = $signed({2'b0, probe.y, 1'b0}) + $signed({3'b0, probe.h});
      bx1 = $signed({2'b0, held.x, 1'b0}) - $signed({3'b0, held.w});
      bx2 = $signed({2'b0, held.x, 1'b0}) + $signed({3'b0, held.w});
      by1 = $signed({2'b0, held.y, 1'b0}) - $signed({3'b0, held.h});
      by2 = $signed({2'b0, held.y, 1'b0}) + $signed({3'b0, held.h});
      ix1 = (ax1 > bx1) ? ax1 : bx1;
      ix2 = (ax2 < bx2) ? ax2 : bx2;
      iy1 = (ay1 > by1) ? ay1 : by1;
      iy2 = (ay2 < by2) ? ay2 : by2;
      ok_in = (ix2 > ix1) && (iy2 > iy1);
      dx_in = 19'(ix2 - ix1);
      dy_in = 19'(iy2 - iy1);
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      ok_ff  <= ok_in;
      aw_ff  <= probe.w;
      ah_ff  <= probe.h;
      bw_ff  <= held.w;
      bh_ff  <= held.h;
      thr_ff <= thr;
   end

   always_comb begin
      inter_in = 38'(dx_ff) * 38'(dy_ff);
      aa_in    = 34'({aw_ff, 2'b0}) * 34'(ah_ff);
      ab_in    = 34'({bw_ff, 2'b0}) * 34'(bh_ff);
   end

   always_ff @(posedge clock) begin
      inter_ff <= inter_in;
      aa_ff    <= aa_in;
      ab_ff    <= ab_in;
      ok2_ff   <= ok_ff;
      thr2_ff  <= thr_ff;
   end

   // union of two boxes never falls below the intersection
   always_comb begin
      uni = 36'(aa_ff) + 36'(ab_ff) - 36'(inter_ff);
      lhs = {15'b0, inter_ff} << 15;
      rhs = 53'(uni) * 53'(thr2_ff);
      hit = ok2_ff && (lhs > rhs);
   end
endmodule

[hw/rtl/bnms_cell.sv]
// One slot of the sorted chain. Holds a box; on load the chain behaves as a
// sorted insertion (a box moves down when the new score beats it).
module bnms_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  bnms_pkg::ctl_type    ctl,
   input  bnms_pkg::box_type    new_box,
   input  bnms_pkg::box_type    up_box,
   input  logic                 up_moves,
   input  logic                 supp_set,
   output bnms_pkg::box_type    box,
   output logic                 moves
);
   bnms_pkg::box_type box_ff, box_in;

   // stable: move down only when strictly beaten
   assign moves = box_ff.valid && (box_ff.score < new_box.score);

   always_comb begin
      box_in = box_ff;
      if (ctl.clear) begin
         box_in.valid = 1'b0;
      end else if (ctl.load) begin
         // take the new box only right behind an occupied neighbour
         if (up_moves) box_in = up_box;
         else if ((moves || !box_ff.valid) && up_box.valid) box_in = new_box;
      end else if (ctl.shift) begin
         box_in = up_box;
      end else if (supp_set) begin
         box_in.supp = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.valid <= 1'b0;
         {box_ff.x, box_ff.y, box_ff.w, box_ff.h, box_ff.score, box_ff.supp} <=
            box_in[81:1];
      end else begin
         box_ff <= box_in;
      end
   end
   assign box = box_ff;
endmodule

[hw/rtl/box_non_maximum_suppression.sv]
// Greedy NMS over up to 64 boxes. A box is accepted each cycle while loading
// (busy low); a sorted chain of cells inserts each box by score as it
// arrives. On the last box, the chain head is taken as probe, every held box
// is tested in parallel against it through the overlap units, the head is
// emitted in the following cycle if it survives, and the chain shifts by one.
// Busy stays high while the held boxes are worked through. Results appear on
// rsp_valid for one cycle each and cannot be stalled; the final survivor
// carries end_of_set.
module box_non_maximum_suppression (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bnms_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output bnms_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [1:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   localparam int N = bnms_pkg::MaxBoxes;

   typedef enum logic [1:0] {LOAD, TEST, EMIT} state_type;
   state_type state_ff;
   logic [1:0] wait_ff;
   logic [15:0] thr_ff;
   logic [bnms_pkg::CntW-1:0] cnt_ff;
   logic ovf_ff;

   bnms_pkg::ctl_type ctl;
   bnms_pkg::box_type new_box, cells [N];
   logic moves [N];
   logic hit [N];
   logic setv [N];
   logic accept, head_keep, chain_empty;

   assign pready = 1'b1;
   assign prdata = {16'b0, thr_ff};
   assign busy = (state_ff != LOAD);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= bnms_pkg::ThrReset;
      else if (psel && penable && pwrite && paddr == 2'd0) thr_ff <= pwdata[15:0];
   end

   always_comb begin
      new_box.x = req_data.center_x;
      new_box.y = req_data.center_y;
      new_box.w = req_data.box_width;
      new_box.h = req_data.box_height;
      new_box.score = req_data.score;
      new_box.supp = req_data.pre_rejected;
      new_box.valid = 1'b1;
   end

   assign chain_empty = !cells[0].valid;
   assign head_keep = cells[0].valid && !cells[0].supp;

   always_comb begin
      ctl.load  = accept && (cnt_ff < bnms_pkg::CntW'(N));
      ctl.shift = (state_ff == EMIT);
      ctl.clear = 1'b0;
      ctl.test  = (state_ff == TEST) && (wait_ff == 2'd3) && head_keep;
   end

   for (genvar k = 0; k < N; k++) begin : g_chain
      bnms_pkg::box_type up;
      logic up_mv;
      if (k == 0) begin : g_top
         assign up = new_box;
         assign up_mv = 1'b0;
      end else begin : g_rest
         assign up = cells[k-1];
         assign up_mv = moves[k-1];
      end
      bnms_iou u_iou (
         .clock (clock), .probe (cells[0]), .held (cells[k]),
         .thr (thr_ff), .hit (hit[k])
      );
      assign setv[k] = ctl.test && (k != 0) && hit[k];
      bnms_cell u_cell (
         .clock (clock), .reset (reset), .ctl (ctl), .new_box (new_box),
         .up_box (k == N-1 && state_ff == EMIT ? '0 :
                  (state_ff == EMIT ? (k + 1 < N ? cells[(k+1) % N] : '0) : up)),
         .up_moves (up_mv), .supp_set (setv[k]),
         .box (cells[k]), .moves (moves[k])
      );
   end

   // an unsuppressed box behind the head is always a later survivor
   logic any_after;
   always_comb begin
      any_after = 1'b0;
      for (int k = 1; k < N; k++)
         if (cells[k].valid && !cells[k].supp && !setv[k]) any_after = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
         wait_ff  <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= ctl.test;
         unique case (state_ff)
            LOAD: begin
               if (accept) begin
                  if (cnt_ff < bnms_pkg::CntW'(N)) cnt_ff <= cnt_ff + 1'b1;
                  else ovf_ff <= 1'b1;
                  if (req_data.last_box) begin
                     state_ff <= TEST;
                     wait_ff  <= '0;
                  end
               end
            end
            TEST: begin
               if (chain_empty) begin
                  state_ff <= LOAD;
                  cnt_ff <= '0;
                  ovf_ff <= 1'b0;
               end else if (wait_ff == 2'd3) begin
                  state_ff <= EMIT;
                  if (head_keep) begin
                     rsp_data.kept_x      <= cells[0].x;
                     rsp_data.kept_y      <= cells[0].y;
                     rsp_data.kept_width  <= cells[0].w;
                     rsp_data.kept_height <= cells[0].h;
                     rsp_data.kept_score  <= cells[0].score;
                     rsp_data.end_of_set  <= !any_after;
                     rsp_data.overflowed  <= ovf_ff;
                  end
               end else begin
                  wait_ff <= wait_ff + 1'b1;
               end
            end
            EMIT: begin
               state_ff <= TEST;
               wait_ff  <= '0;
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_no_rsp_in_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LOAD && $past(state_ff) == LOAD) |-> !rsp_valid)
      else $error("result while loading");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bnms_pkg::CntW'(N))
      else $error("count beyond capacity");
   a_eos_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.end_of_set) |=> !rsp_valid)
      else $error("result after end of set");
`endif
endmodule

[tb/sv/tb_box_non_maximum_suppression.sv]
`timescale 1ns / 1ps

module tb_box_non_maximum_suppression;

   localparam int LimitCycles = 2000000;
   localparam logic [1:0] AddrIouThreshold = 2'd0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bnms_pkg::req_type req_data = '0;
   logic rsp_valid;
   bnms_pkg::rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   box_non_maximum_suppression i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   bnms_pkg::req_type held_boxes[$];
   logic overflow_pending;
   logic [15:0] iou_thr;
   bnms_pkg::rsp_type survivors_due[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 21;

   function automatic logic too_much_overlap(bnms_pkg::req_type a, bnms_pkg::req_type b,
                                             logic [15:0] thr);
      longint ax1, ax2, ay1, ay2, bx1, bx2, by1, by2, ix1, ix2, iy1, iy2;
      longint inter, uni;
      ax1 = 2 * longint'(a.center_x) - a.box_width;
      ax2 = 2 * longint'(a.center_x) + a.box_width;
      ay1 = 2 * longint'(a.center_y) - a.box_height;
      ay2 = 2 * longint'(a.center_y) + a.box_height;
      bx1 = 2 * longint'(b.center_x) - b.box_width;
      bx2 = 2 * longint'(b.center_x) + b.box_width;
      by1 = 2 * longint'(b.center_y) - b.box_height;
      by2 = 2 * longint'(b.center_y) + b.box_height;
      ix1 = ax1 > bx1 ? ax1 : bx1;
      iy1 = ay1 > by1 ? ay1 : by1;
      ix2 = ax2 < bx2 ? ax2 : bx2;
      iy2 = ay2 < by2 ? ay2 : by2;
      if (ix2 <= ix1 || iy2 <= iy1) return 1'b0;
      inter = (ix2 - ix1) * (iy2 - iy1);
      uni = 4 * longint'(a.box_width) * a.box_height
          + 4 * longint'(b.box_width) * b.box_height - inter;
      return inter * 32768 > uni * longint'(thr);
   endfunction

   task automatic predict_box(bnms_pkg::req_type r);
      bnms_pkg::req_type ranked[$];
      logic dead[$];
      int j;
      bnms_pkg::rsp_type o;
      int first_kept;
      if (held_boxes.size() < bnms_pkg::MaxBoxes) held_boxes.insert(held_boxes.size(), r);
      else overflow_pending = 1'b1;
      if (!r.last_box) return;
      // stable descending insertion
      foreach (held_boxes[i]) begin
         j = ranked.size();
         while (j > 0 && ranked[j-1].score < held_boxes[i].score) j--;
         ranked.insert(j, held_boxes[i]);
      end
      foreach (ranked[i]) dead.insert(dead.size(), ranked[i].pre_rejected);
      first_kept = survivors_due.size();
      foreach (ranked[i]) begin
         if (dead[i]) continue;
         for (int k = i + 1; k < ranked.size(); k++)
            if (!dead[k] && too_much_overlap(ranked[i], ranked[k], iou_thr)) dead[k] = 1'b1;
         o.kept_x      = ranked[i].center_x;
         o.kept_y      = ranked[i].center_y;
         o.kept_width  = ranked[i].box_width;
         o.kept_height = ranked[i].box_height;
         o.kept_score  = ranked[i].score;
         o.end_of_set  = 1'b0;
         o.overflowed  = overflow_pending;
         survivors_due.insert(survivors_due.size(), o);
      end
      if (survivors_due.size() > first_kept)
         survivors_due[survivors_due.size()-1].end_of_set = 1'b1;
      held_boxes.delete();
      overflow_pending = 1'b0;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (survivors_due.size() == 0) begin
            $error("unexpected survivor x=%0d score=%0d",
                   rsp_data.kept_x, rsp_data.kept_score);
            errors++;
         end else begin
            bnms_pkg::rsp_type e;
            e = survivors_due.pop_front();
            if (e.kept_x !== rsp_data.kept_x)
               begin $error("kept_x exp %0d got %0d", e.kept_x, rsp_data.kept_x); errors++; end
            if (e.kept_y !== rsp_data.kept_y)
               begin $error("kept_y exp %0d got %0d", e.kept_y, rsp_data.kept_y); errors++; end
            if (e.kept_width !== rsp_data.kept_width)
               begin $error("kept_width exp %0d got %0d", e.kept_width, rsp_data.kept_width);
                  errors++; end
            if (e.kept_height !== rsp_data.kept_height)
               begin $error("kept_height exp %0d got %0d", e.kept_height, rsp_data.kept_height);
                  errors++; end
            if (e.kept_score !== rsp_data.kept_score)
               begin $error("kept_score exp %0d got %0d", e.kept_score, rsp_data.kept_score);
                  errors++; end
            if (e.end_of_set !== rsp_data.end_of_set)
               begin $error("end_of_set exp %0d got %0d", e.end_of_set, rsp_data.end_of_set);
                  errors++; end
            if (e.overflowed !== rsp_data.overflowed)
               begin $error("overflowed exp %0d got %0d", e.overflowed, rsp_data.overflowed);
                  errors++; end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= LimitCycles) begin
         $display("[box_non_maximum_suppression] ERROR");
         $finish;
      end
   end

   task automatic write_threshold(logic [15:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrIouThreshold; pwdata <= {16'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      iou_thr = value;
      @(negedge clock);
      psel <= 1'b1; paddr <= AddrIouThreshold;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[15:0] !== value) begin
         $error("iou_threshold exp %0d got %0d", value, prdata[15:0]);
         errors++;
      end
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   // drop the request, drain every pending survivor, then let the chain settle
   task automatic wait_idle();
      start <= 1'b0;
      while (survivors_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // present one box at a falling edge and hold until taken
   task automatic send_box(bnms_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_box(r);
      @(negedge clock);
   endtask

   function automatic bnms_pkg::req_type make_box(int lo, int hi, logic last);
      bnms_pkg::req_type r;
      r.center_x     = 16'($urandom_range(hi, lo));
      r.center_y     = 16'($urandom_range(hi, lo));
      r.box_width    = 16'($urandom_range(hi - lo, 0));
      r.box_height   = 16'($urandom_range(hi - lo, 0));
      r.score        = 16'($urandom_range(7) == 0 ? $urandom_range(3) : $urandom());
      r.pre_rejected = ($urandom_range(9) == 0);
      r.last_box     = last;
      return r;
   endfunction

   task automatic random_set(int n, int span_lo, int span_hi);
      for (int i = 0; i < n; i++) send_box(make_box(span_lo, span_hi, i == n - 1));
   endtask

   typedef struct {
      bnms_pkg::req_type box;
      logic              typed;
      bnms_pkg::rsp_type exp;
   } directed_row;

   directed_row directed[] = '{
      // single box, maximum fields
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}, 1'b1,
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0}},
      // single box, all zero
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1}, 1'b1,
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0}},
      // rejected-only set emits nothing
      '{'{16'd100, 16'd100, 16'd10, 16'd10, 16'd500, 1'b1, 1'b1}, 1'b0, '0},
      // identical boxes, equal scores: first kept
      '{'{16'd50, 16'd50, 16'd20, 16'd20, 16'd900, 1'b0, 1'b0}, 1'b0, '0},
      '{'{16'd50, 16'd50, 16'd20, 16'd20, 16'd900, 1'b0, 1'b1}, 1'b0, '0},
      // touching boxes never suppress
      '{'{16'd10, 16'd10, 16'd10, 16'd10, 16'd300, 1'b0, 1'b0}, 1'b0, '0},
      '{'{16'd20, 16'd10, 16'd10, 16'd10, 16'd400, 1'b0, 1'b1}, 1'b0, '0},
      // zero-size inside a big box
      '{'{16'd40, 16'd40, 16'd0, 16'd5, 16'd800, 1'b0, 1'b0}, 1'b0, '0},
      '{'{16'd40, 16'd40, 16'd30, 16'd30, 16'd100, 1'b0, 1'b1}, 1'b0, '0},
      // partial overlap, ascending scores, a rejected box in the middle
      '{'{16'd100, 16'd100, 16'd40, 16'd40, 16'd1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{16'd105, 16'd100, 16'd40, 16'd40, 16'd2, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd110, 16'd100, 16'd40, 16'd40, 16'd3, 1'b0, 1'b1}, 1'b0, '0},
      // far corner extremes
      '{'{16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 1'b0, 1'b0}, 1'b0, '0},
      '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b0, 1'b1}, 1'b0, '0}
   };

   initial begin
      bnms_pkg::req_type r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      held_boxes.delete();
      overflow_pending = 1'b0;
      iou_thr = bnms_pkg::ThrReset;
      @(posedge clock);
      if (prdata !== {16'd0, bnms_pkg::ThrReset}) begin
         $error("iou_threshold exp %0d got %0d", bnms_pkg::ThrReset, prdata);
         errors++;
      end
      @(negedge clock);

      foreach (directed[i]) begin
         send_box(directed[i].box);
         if (directed[i].typed && survivors_due.size() != 0)
            survivors_due[survivors_due.size()-1] = directed[i].exp;
      end
      wait_idle();

      // capacity: 70 boxes, the six beyond 64 dropped, the last of them still ends the set
      for (int i = 0; i < 70; i++) begin
         r = make_box(0, 65535, i == 69);
         send_box(r);
      end
      wait_idle();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 80 : 0;
         case (phase)
            0: write_threshold(16'd0);
            1: write_threshold(16'd32768);
            default: write_threshold(16'hFFFF);
         endcase
         for (int s = 0; s < 10; s++) random_set($urandom_range(10, 1), 100, 140);
         wait_idle();
         write_threshold(phase == 2 ? bnms_pkg::ThrReset : 16'($urandom_range(32768)));
         for (int s = 0; s < 11; s++) random_set($urandom_range(12, 1), 100, 160);
         // hold the sender until the set has drained
         start <= 1'b0;
         do @(negedge clock); while (survivors_due.size() != 0);
         random_set(3, 0, 65535);
         wait_idle();
      end
      write_threshold(16'd1);
      random_set(8, 200, 230);
      wait_idle();

      if (errors == 0) $display("[box_non_maximum_suppression] OK");
      else $display("[box_non_maximum_suppression] ERROR");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/bnms_pkg.sv
hw/rtl/bnms_iou.sv
hw/rtl/bnms_cell.sv
hw/rtl/box_non_maximum_suppression.sv
tb/sv/tb_box_non_maximum_suppression.sv
